// File: rtl/grid_point_chained_hash_unit_macros.svh
// ---------------------------------------------------------------------------
// Grid point chained hash unit: assertion macros
// Shorthand for clocked implication checks with an asynchronous reset.
// ---------------------------------------------------------------------------
`ifndef GRID_POINT_CHAINED_HASH_UNIT_MACROS_SVH
`define GRID_POINT_CHAINED_HASH_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define GCPH_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define GCPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: rtl/gcph_pkg.sv
// ---------------------------------------------------------------------------
// Grid point chained hash unit: package
// Field widths, parameter defaults, command codes and control types.
// ---------------------------------------------------------------------------
package gcph_pkg;

	localparam int unsigned BUCKET_COUNT_DEF = 211;
	localparam int unsigned NODE_COUNT_DEF   = 4096;
	localparam int unsigned COORD_BITS_DEF   = 10;

	localparam int unsigned CMD_W          = 2;
	localparam int unsigned COORD_FIELD_W  = 10;
	localparam int unsigned POINT_W        = 12;
	localparam int unsigned HASH_ROW_SHIFT = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOOKUP  = 2'd0,
		CMD_INSTALL = 2'd1,
		CMD_CLEAR   = 2'd2
	} cmd_t;

	typedef struct packed {
		logic load;
		logic quot;
		logic rem;
	} hash_ctrl_t;

endpackage

// File: rtl/gcph_ifs.sv
// ---------------------------------------------------------------------------
// Grid point chained hash unit: channel interfaces
// Request and response channels with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface gcph_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [gcph_pkg::CMD_W-1:0]            command;
	logic [gcph_pkg::COORD_FIELD_W-1:0]    row_index;
	logic [gcph_pkg::COORD_FIELD_W-1:0]    column_index;
	logic [gcph_pkg::POINT_W-1:0]          point_number;

	modport source (output valid, command, row_index, column_index, point_number,
		input ready);
	modport sink (input valid, command, row_index, column_index, point_number,
		output ready);
endinterface

interface gcph_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         found;
	logic [gcph_pkg::POINT_W-1:0] result_point;

	modport source (output valid, found, result_point, input ready);
	modport sink (input valid, found, result_point, output ready);
endinterface

// File: rtl/grid_point_chained_hash_unit.sv
// ---------------------------------------------------------------------------
// Grid point chained hash unit
// Maps grid coordinates to a point number through a separately chained hash
// table: a bucket head RAM and a node RAM walked by a small sequencer.
//
//   Channel  Role    Payload                                         Handshake
//   req      sink    command, row_index, column_index, point_number  valid/ready
//   rsp      source  found, result_point                             valid/ready
//
// An install or a miss on an empty bucket passes through QUOT, REM, HEAD and
// LINK from acceptance to the result register; a lookup adds one NODE visit
// per visited node, one node RAM read per node. A clear sweeps every bucket in CLR.
// After reset every bucket of the head RAM is cleared in INIT before the
// first transaction is accepted. A stalled response holds the result register;
// the next request is accepted while it waits.
// ---------------------------------------------------------------------------
module grid_point_chained_hash_unit #(
	parameter int unsigned BUCKET_COUNT = gcph_pkg::BUCKET_COUNT_DEF,
	parameter int unsigned NODE_COUNT   = gcph_pkg::NODE_COUNT_DEF,
	parameter int unsigned COORD_BITS   = gcph_pkg::COORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	gcph_req_if.sink  req,
	gcph_rsp_if.source rsp
);

	import gcph_pkg::*;

	localparam int unsigned CW      = (COORD_BITS < COORD_FIELD_W) ? COORD_BITS : COORD_FIELD_W;
	localparam int unsigned BKT_W   = $clog2(BUCKET_COUNT);
	localparam int unsigned NODE_W  = $clog2(NODE_COUNT);
	localparam int unsigned HEAD_W  = NODE_W + 1;
	localparam int unsigned ENTRY_W = HEAD_W + 2 * CW;
	localparam int unsigned STEP_W  = NODE_W + 1;
	localparam int unsigned CMP_W   = ((NODE_W > POINT_W) ? NODE_W : POINT_W) + 1;
	localparam logic [BKT_W-1:0] LAST_BKT = BKT_W'(BUCKET_COUNT - 1);

	typedef enum logic [8:0] {
		S_INIT = 9'b000000001,
		S_IDLE = 9'b000000010,
		S_QUOT = 9'b000000100,
		S_REM  = 9'b000001000,
		S_HEAD = 9'b000010000,
		S_LINK = 9'b000100000,
		S_NODE = 9'b001000000,
		S_CLR  = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	state_t             state_q, state_d;
	cmd_t               cmd_q;
	logic [CW-1:0]      row_q, col_q;
	logic [POINT_W-1:0] pt_q;
	logic [NODE_W-1:0]  cur_q, cur_d;
	logic [STEP_W-1:0]  step_q, step_d;
	logic [BKT_W-1:0]   clr_q, clr_d;
	logic               res_found_q, res_found_d;
	logic [POINT_W-1:0] res_pt_q, res_pt_d;
	logic               out_valid_q;
	logic               out_found_q;
	logic [POINT_W-1:0] out_pt_q;

	hash_ctrl_t         hctrl;
	logic [BKT_W-1:0]   bucket;
	logic               head_we;
	logic [BKT_W-1:0]   head_waddr;
	logic [HEAD_W-1:0]  head_wdata;
	logic [HEAD_W-1:0]  head_rd;
	logic               node_we;
	logic [NODE_W-1:0]  node_raddr;
	logic [ENTRY_W-1:0] node_rd;
	logic [NODE_W-1:0]  pt_node;
	logic               pt_ok;
	logic               accept;
	logic               out_load;

	assign accept  = req.valid && (state_q == S_IDLE);
	assign pt_node = NODE_W'(pt_q);
	assign pt_ok   = CMP_W'(pt_q) < CMP_W'(NODE_COUNT);

	gcph_bucket_hash #(
		.BUCKET_COUNT(BUCKET_COUNT),
		.COORD_W     (CW)
	) u_hash (
		.clk   (clk),
		.ctrl  (hctrl),
		.row   (req.row_index[CW-1:0]),
		.col   (req.column_index[CW-1:0]),
		.bucket(bucket)
	);

	gcph_ram #(
		.WIDTH(HEAD_W),
		.DEPTH(BUCKET_COUNT)
	) u_head_ram (
		.clk    (clk),
		.wr_en  (head_we),
		.wr_addr(head_waddr),
		.wr_data(head_wdata),
		.rd_addr(bucket),
		.rd_data(head_rd)
	);

	gcph_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NODE_COUNT)
	) u_node_ram (
		.clk    (clk),
		.wr_en  (node_we),
		.wr_addr(pt_node),
		.wr_data({head_rd, row_q, col_q}),
		.rd_addr(node_raddr),
		.rd_data(node_rd)
	);

	always_comb begin
		state_d     = state_q;
		hctrl       = '0;
		head_we     = 1'b0;
		head_waddr  = bucket;
		head_wdata  = '0;
		node_we     = 1'b0;
		node_raddr  = cur_q;
		cur_d       = cur_q;
		step_d      = step_q;
		clr_d       = clr_q;
		res_found_d = res_found_q;
		res_pt_d    = res_pt_q;
		out_load    = 1'b0;
		unique case (state_q)
			S_INIT, S_CLR: begin
				head_we    = 1'b1;
				head_waddr = clr_q;
				if (clr_q == LAST_BKT) begin
					clr_d = '0;
					if (state_q == S_INIT) begin
						state_d = S_IDLE;
					end else begin
						res_found_d = 1'b0;
						res_pt_d    = '0;
						state_d     = S_DONE;
					end
				end else begin
					clr_d = clr_q + BKT_W'(1);
				end
			end
			S_IDLE: begin
				if (accept) begin
					hctrl.load = 1'b1;
					state_d    = S_QUOT;
				end
			end
			S_QUOT: begin
				hctrl.quot = 1'b1;
				state_d    = S_REM;
			end
			S_REM: begin
				hctrl.rem = 1'b1;
				state_d   = S_HEAD;
			end
			S_HEAD: begin
				state_d = S_LINK;
			end
			S_LINK: begin
				res_found_d = 1'b0;
				res_pt_d    = '0;
				state_d     = S_DONE;
				unique case (cmd_q)
					CMD_INSTALL: begin
						if (pt_ok) begin
							head_we     = 1'b1;
							head_wdata  = {1'b1, pt_node};
							node_we     = 1'b1;
							res_found_d = 1'b1;
							res_pt_d    = pt_q;
						end
					end
					CMD_LOOKUP: begin
						if (head_rd[NODE_W]) begin
							node_raddr = head_rd[NODE_W-1:0];
							cur_d      = head_rd[NODE_W-1:0];
							step_d     = STEP_W'(1);
							state_d    = S_NODE;
						end
					end
					CMD_CLEAR: begin
						clr_d   = '0;
						state_d = S_CLR;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_NODE: begin
				if (node_rd[CW +: CW] == row_q && node_rd[0 +: CW] == col_q) begin
					res_found_d = 1'b1;
					res_pt_d    = POINT_W'(cur_q);
					state_d     = S_DONE;
				end else if (!node_rd[ENTRY_W-1] || step_q == STEP_W'(NODE_COUNT)) begin
					res_found_d = 1'b0;
					res_pt_d    = '0;
					state_d     = S_DONE;
				end else begin
					node_raddr = node_rd[2 * CW +: NODE_W];
					cur_d      = node_rd[2 * CW +: NODE_W];
					step_d     = step_q + STEP_W'(1);
				end
			end
			S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
				clr_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(req.command);
			row_q <= req.row_index[CW-1:0];
			col_q <= req.column_index[CW-1:0];
			pt_q  <= req.point_number;
		end
		cur_q       <= cur_d;
		step_q      <= step_d;
		res_found_q <= res_found_d;
		res_pt_q    <= res_pt_d;
		if (out_load) begin
			out_found_q <= res_found_q;
			out_pt_q    <= res_pt_q;
		end
	end

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.found        = out_found_q;
	assign rsp.result_point = out_pt_q;

endmodule

// File: rtl/gcph_ram.sv
// ---------------------------------------------------------------------------
// Grid point chained hash unit: generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module gcph_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/gcph_bucket_hash.sv
// ---------------------------------------------------------------------------
// Grid point chained hash unit: bucket hash
// Computes ((row << 4) + column) mod BUCKET_COUNT in two multiply steps:
// a reciprocal multiply for the quotient, then a multiply back for the rest.
// ---------------------------------------------------------------------------
module gcph_bucket_hash #(
	parameter int unsigned BUCKET_COUNT = gcph_pkg::BUCKET_COUNT_DEF,
	parameter int unsigned COORD_W      = gcph_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  gcph_pkg::hash_ctrl_t            ctrl,
	input  logic [COORD_W-1:0]              row,
	input  logic [COORD_W-1:0]              col,
	output logic [$clog2(BUCKET_COUNT)-1:0] bucket
);

	import gcph_pkg::*;

	localparam int unsigned SUM_W  = COORD_W + HASH_ROW_SHIFT + 1;
	localparam int unsigned BKT_W  = $clog2(BUCKET_COUNT);
	localparam int unsigned SHIFT  = SUM_W + BKT_W;
	localparam int unsigned MULT_W = SUM_W + 2;
	localparam int unsigned PROD_W = SUM_W + MULT_W;
	localparam int unsigned BACK_W = SUM_W + BKT_W + 1;
	localparam logic [MULT_W-1:0] RECIP = MULT_W'((64'd1 << SHIFT) / BUCKET_COUNT + 1);

	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  quot_q;
	logic [BKT_W-1:0]  bucket_q;
	logic [PROD_W-1:0] prod;
	logic [BACK_W-1:0] back;
	logic [SUM_W-1:0]  rem;

	assign prod = PROD_W'(sum_q) * PROD_W'(RECIP);
	assign back = BACK_W'(quot_q) * BACK_W'(BUCKET_COUNT);
	assign rem  = sum_q - SUM_W'(back);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			sum_q <= (SUM_W'(row) << HASH_ROW_SHIFT) + SUM_W'(col);
		end
		if (ctrl.quot) begin
			quot_q <= SUM_W'(prod >> SHIFT);
		end
		if (ctrl.rem) begin
			bucket_q <= BKT_W'(rem);
		end
	end

	assign bucket = bucket_q;

endmodule

// File: rtl/gcph_checker.sv
// ---------------------------------------------------------------------------
// Grid point chained hash unit: port checker
// Watches the channel ports of the top level and checks their behavior.
// ---------------------------------------------------------------------------
`include "grid_point_chained_hash_unit_macros.svh"

module gcph_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic                         rsp_found,
	input logic [gcph_pkg::POINT_W-1:0] rsp_result_point
);

	`GCPH_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready, "request accepted while a transaction is in progress")
	`GCPH_ASSERT_NEXT(a_no_instant_result, clk, arst_n, req_valid && req_ready, !$rose(rsp_valid), "response raised one cycle after acceptance")
	`GCPH_ASSERT_SAME(a_miss_is_zero, clk, arst_n, rsp_valid && !rsp_found, rsp_result_point == '0, "response without a match carries a nonzero point")
	`GCPH_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_found) && $stable(rsp_result_point), "stalled response changed")

endmodule

bind grid_point_chained_hash_unit gcph_checker u_gcph_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_found       (rsp.found),
	.rsp_result_point(rsp.result_point)
);
